### src/pl_pkg.sv
// ----------------------------------------------------------------------------
// pl_pkg
// Shared types and codes for the positional list engine: command modes,
// status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package pl_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_HEAD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM_TAIL = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REM_POS  = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_REM
  } pl_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAB,
    ST_TAKE,
    ST_READ,
    ST_WRITE,
    ST_FILL,
    ST_PUSH
  } pl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic grab;
    logic take;
    logic rd;
    logic wr;
    logic fill;
    logic finish;
  } pl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_ok;
    logic rem_ok;
    logic ins_shift;
    logic more;
    logic more_step;
    logic op_ins;
    logic out_free;
  } pl_sts_t;

endpackage

### src/pl_ctrl.sv
// ----------------------------------------------------------------------------
// pl_ctrl
// Sequencer for the list engine: accepts a command, steps the entry shift
// one move at a time (read, then write) and hands the result to the output.
// ----------------------------------------------------------------------------
module pl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pl_pkg::pl_sts_t sts_i,
  output pl_pkg::pl_cmd_t cmd_o
);

  pl_pkg::pl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.ins_ok) begin
            state_d = sts_i.ins_shift ? pl_pkg::ST_READ : pl_pkg::ST_FILL;
          end else if (sts_i.rem_ok) begin
            state_d = pl_pkg::ST_GRAB;
          end else begin
            state_d = pl_pkg::ST_PUSH;
          end
        end
      end
      pl_pkg::ST_GRAB:  state_d = pl_pkg::ST_TAKE;
      pl_pkg::ST_TAKE:  state_d = sts_i.more ? pl_pkg::ST_READ : pl_pkg::ST_PUSH;
      pl_pkg::ST_READ:  state_d = pl_pkg::ST_WRITE;
      pl_pkg::ST_WRITE: begin
        if (sts_i.more_step) begin
          state_d = pl_pkg::ST_READ;
        end else begin
          state_d = sts_i.op_ins ? pl_pkg::ST_FILL : pl_pkg::ST_PUSH;
        end
      end
      pl_pkg::ST_FILL:  state_d = pl_pkg::ST_PUSH;
      pl_pkg::ST_PUSH:  state_d = sts_i.out_free ? pl_pkg::ST_IDLE : pl_pkg::ST_PUSH;
      default:          state_d = pl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      pl_pkg::ST_IDLE:  cmd_o.accept = in_valid_i;
      pl_pkg::ST_GRAB:  cmd_o.grab   = 1'b1;
      pl_pkg::ST_TAKE:  cmd_o.take   = 1'b1;
      pl_pkg::ST_READ:  cmd_o.rd     = 1'b1;
      pl_pkg::ST_WRITE: cmd_o.wr     = 1'b1;
      pl_pkg::ST_FILL:  cmd_o.fill   = 1'b1;
      pl_pkg::ST_PUSH:  cmd_o.finish = sts_i.out_free;
      default:          cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != pl_pkg::ST_IDLE);

  // a shift write always consumes the word fetched the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pl_pkg::ST_WRITE |-> $past(state_q) == pl_pkg::ST_READ)
    else $error("shift write without preceding read");

endmodule

### src/pl_datapath.sv
// ----------------------------------------------------------------------------
// pl_datapath
// Entry memory, count, command decode and result register of the list
// engine. Entries move one word per read/write pair under controller command.
// ----------------------------------------------------------------------------
module pl_datapath #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned CNT_W       = $clog2(CAPACITY + 1),
  parameter int unsigned ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pl_pkg::pl_cmd_t               cmd_i,
  output pl_pkg::pl_sts_t               sts_o,
  input  logic [pl_pkg::MODE_W-1:0]     mode_i,
  input  logic [CNT_W-1:0]              position_i,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [VALUE_WIDTH-1:0]        removed_value_o,
  output logic [pl_pkg::STATUS_W-1:0]   status_o,
  output logic [CNT_W-1:0]              count_o
);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]              count_q;
  logic [CNT_W-1:0]              count_next;
  logic                          out_valid_q;
  pl_pkg::pl_op_e                op_q;
  logic [pl_pkg::STATUS_W-1:0]   status_q;
  logic [ADDR_W-1:0]             at_q;
  logic [ADDR_W-1:0]             cursor_q;
  logic [VALUE_WIDTH-1:0]        value_q;
  logic [VALUE_WIDTH-1:0]        removed_q;
  logic [VALUE_WIDTH-1:0]        rd_data_q;

  logic [VALUE_WIDTH-1:0]        res_removed_q;
  logic [pl_pkg::STATUS_W-1:0]   res_status_q;
  logic [CNT_W-1:0]              res_count_q;

  // decode of the incoming command against the current count
  pl_pkg::pl_op_e                acc_op;
  logic [pl_pkg::STATUS_W-1:0]   acc_status;
  logic [CNT_W-1:0]              acc_at;
  logic                          is_full;
  logic                          is_empty;

  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    acc_op     = pl_pkg::OP_NONE;
    acc_status = pl_pkg::STAT_OK;
    acc_at     = '0;
    case (mode_i)
      pl_pkg::MODE_INS_HEAD, pl_pkg::MODE_INS_TAIL, pl_pkg::MODE_INS_POS: begin
        acc_at = (mode_i == pl_pkg::MODE_INS_HEAD) ? '0
               : (mode_i == pl_pkg::MODE_INS_TAIL) ? count_q : position_i;
        if (is_full) begin
          acc_status = pl_pkg::STAT_FULL;
        end else if (acc_at > count_q) begin
          acc_status = pl_pkg::STAT_BADPOS;
        end else begin
          acc_op = pl_pkg::OP_INS;
        end
      end
      pl_pkg::MODE_REM_HEAD, pl_pkg::MODE_REM_TAIL, pl_pkg::MODE_REM_POS: begin
        acc_at = (mode_i == pl_pkg::MODE_REM_HEAD) ? '0
               : (mode_i == pl_pkg::MODE_REM_TAIL) ? (count_q - CNT_W'(1)) : position_i;
        if (is_empty) begin
          acc_status = pl_pkg::STAT_EMPTY;
        end else if (acc_at >= count_q) begin
          acc_status = pl_pkg::STAT_BADPOS;
        end else begin
          acc_op = pl_pkg::OP_REM;
        end
      end
      default: ;
    endcase
  end

  // insert walks the cursor down toward at_q, remove walks it up toward the tail
  logic ins_more, ins_more_step, rem_more, rem_more_step;
  assign ins_more      = (cursor_q > at_q);
  assign ins_more_step = ((cursor_q - ADDR_W'(1)) > at_q);
  assign rem_more      = ((CNT_W'(cursor_q) + CNT_W'(1)) < count_q);
  assign rem_more_step = ((CNT_W'(cursor_q) + CNT_W'(2)) < count_q);

  assign sts_o.ins_ok    = (acc_op == pl_pkg::OP_INS);
  assign sts_o.rem_ok    = (acc_op == pl_pkg::OP_REM);
  assign sts_o.ins_shift = (count_q > acc_at);
  assign sts_o.op_ins    = (op_q == pl_pkg::OP_INS);
  assign sts_o.more      = sts_o.op_ins ? ins_more : rem_more;
  assign sts_o.more_step = sts_o.op_ins ? ins_more_step : rem_more_step;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (op_q)
      pl_pkg::OP_INS: count_next = count_q + CNT_W'(1);
      pl_pkg::OP_REM: count_next = count_q - CNT_W'(1);
      default:        count_next = count_q;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        count_q     <= count_next;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers of the command in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= acc_op;
      status_q  <= acc_status;
      at_q      <= acc_at[ADDR_W-1:0];
      cursor_q  <= (acc_op == pl_pkg::OP_INS) ? count_q[ADDR_W-1:0] : acc_at[ADDR_W-1:0];
      value_q   <= value_i;
      removed_q <= '0;
    end
    if (cmd_i.take) begin
      removed_q <= rd_data_q;
    end
    if (cmd_i.wr) begin
      cursor_q <= (op_q == pl_pkg::OP_INS) ? (cursor_q - ADDR_W'(1))
                                           : (cursor_q + ADDR_W'(1));
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_removed_q <= removed_q;
      res_status_q  <= status_q;
      res_count_q   <= count_next;
    end
  end

  // entry memory: one read and one write port, registered read
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic              wr_en;

  assign rd_en   = cmd_i.grab || cmd_i.rd;
  assign rd_addr = cmd_i.grab               ? cursor_q
                 : (op_q == pl_pkg::OP_INS) ? (cursor_q - ADDR_W'(1))
                                            : (cursor_q + ADDR_W'(1));
  assign wr_en   = cmd_i.wr || cmd_i.fill;
  assign wr_addr = cmd_i.fill ? at_q : cursor_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.fill ? value_q : rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = res_removed_q;
  assign status_o        = res_status_q;
  assign count_o         = res_count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && op_q == pl_pkg::OP_REM |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not drop the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && op_q != pl_pkg::OP_NONE |-> status_q == pl_pkg::STAT_OK)
    else $error("list changed on a failed command");

endmodule

### src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY values with insert/remove at head, tail or
// a given position. One result beat per command.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries mode, position, value.
//   Output channel (out_valid_o / out_stall_i) returns removed value (zero
//   unless a remove succeeded), status (ok, full, empty, bad position) and
//   the count after the command.
//   Commands run one at a time. Entries live in a single-port-read,
//   single-port-write memory, so each entry moved takes a read and a write:
//   an insert shifts the entries from position p up, then writes the value,
//   a remove reads the entry at p and shifts the later entries down; head
//   inserts and tail removes are the long and short extremes. Commands that
//   fail or carry an unused mode go straight to the result beat. The next
//   command is taken the cycle after the result enters the output register.
//   A stalled result holds in the output register while the next command
//   is already processed; that command then waits to load its result.
//   Reset empties the list and drops any pending result; the memory needs
//   no clearing since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter  int unsigned CAPACITY    = 64,
  parameter  int unsigned VALUE_WIDTH = 16,
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pl_pkg::MODE_W-1:0]     mode_i,
  input  logic [CNT_W-1:0]              position_i,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VALUE_WIDTH-1:0]        removed_value_o,
  output logic [pl_pkg::STATUS_W-1:0]   status_o,
  output logic [CNT_W-1:0]              count_o
);

  pl_pkg::pl_cmd_t cmd;
  pl_pkg::pl_sts_t sts;

  pl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pl_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .count_o         (count_o)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_list_engine. Commands go in through the
// valid/stall input channel. A shadow copy of the list predicts each result
// beat, and the checker compares every returned beat field by field in order.
// Random gaps on the input side and random stalls on the output side are
// mixed with stretches that run at full rate.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LIST_CAP    = 64;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [15:0]                 removed;
    logic [pl_pkg::STATUS_W-1:0] status;
    logic [6:0]                  count;
  } list_reply_t;

  localparam logic [pl_pkg::MODE_W-1:0] INS_MODES [3] =
    '{pl_pkg::MODE_INS_HEAD, pl_pkg::MODE_INS_TAIL, pl_pkg::MODE_INS_POS};
  localparam logic [pl_pkg::MODE_W-1:0] REM_MODES [3] =
    '{pl_pkg::MODE_REM_HEAD, pl_pkg::MODE_REM_TAIL, pl_pkg::MODE_REM_POS};

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic [pl_pkg::MODE_W-1:0]   mode_i      = '0;
  logic [6:0]                  position_i  = '0;
  logic [15:0]                 value_i     = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [15:0]                 removed_value_o;
  logic [pl_pkg::STATUS_W-1:0] status_o;
  logic [6:0]                  count_o;

  // shadow list that mirrors the engine
  logic [15:0]  shadow_list [LIST_CAP];
  int unsigned  shadow_cnt   = 0;
  list_reply_t  pending_replies [$];

  int unsigned err_cnt      = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  positional_list_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .count_o         (count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short idle runs, now and then a long one
  function automatic int unsigned idle_len(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic list_reply_t apply_to_shadow(logic [pl_pkg::MODE_W-1:0] mode,
                                                  logic [6:0] pos, logic [15:0] val);
    list_reply_t r;
    int unsigned at;
    r = '{removed: '0, status: pl_pkg::STAT_OK, count: '0};
    case (mode)
      pl_pkg::MODE_INS_HEAD, pl_pkg::MODE_INS_TAIL, pl_pkg::MODE_INS_POS: begin
        at = (mode == pl_pkg::MODE_INS_HEAD) ? 0
           : (mode == pl_pkg::MODE_INS_TAIL) ? shadow_cnt : pos;
        if (shadow_cnt >= LIST_CAP) r.status = pl_pkg::STAT_FULL;
        else if (at > shadow_cnt) r.status = pl_pkg::STAT_BADPOS;
        else begin
          for (int k = shadow_cnt; k > at; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[at] = val;
          shadow_cnt++;
        end
      end
      pl_pkg::MODE_REM_HEAD, pl_pkg::MODE_REM_TAIL, pl_pkg::MODE_REM_POS: begin
        if (shadow_cnt == 0) r.status = pl_pkg::STAT_EMPTY;
        else begin
          at = (mode == pl_pkg::MODE_REM_HEAD) ? 0
             : (mode == pl_pkg::MODE_REM_TAIL) ? shadow_cnt - 1 : pos;
          if (at >= shadow_cnt) r.status = pl_pkg::STAT_BADPOS;
          else begin
            r.removed = shadow_list[at];
            for (int k = at; k + 1 < shadow_cnt; k++) shadow_list[k] = shadow_list[k+1];
            shadow_cnt--;
          end
        end
      end
      default: ;  // unused modes leave the list alone
    endcase
    r.count = shadow_cnt[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    if (err_cnt < MAX_REPORTS)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp);
    err_cnt++;
  endtask

  // drive one command beat and wait until the engine takes it
  task automatic send_cmd(logic [pl_pkg::MODE_W-1:0] mode, logic [6:0] pos,
                          logic [15:0] val);
    int unsigned gap;
    gap = idle_len(gap_pct);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.push_back(apply_to_shadow(mode, pos, val));
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic test_empty_list();
    send_cmd(pl_pkg::MODE_REM_HEAD, 7'd0, 16'hFFFF);
    send_cmd(pl_pkg::MODE_REM_TAIL, 7'd0, 16'h0000);
    send_cmd(pl_pkg::MODE_REM_POS, 7'd0, 16'h0000);
    send_cmd(pl_pkg::MODE_REM_POS, 7'd127, 16'h0000);  // empty wins over bad position
    send_cmd(pl_pkg::MODE_INS_POS, 7'd1, 16'h1111);
    send_cmd(pl_pkg::MODE_INS_POS, 7'd127, 16'h2222);
    send_cmd(3'd6, 7'd0, 16'h3333);
    send_cmd(3'd7, 7'd127, 16'hFFFF);
    send_cmd(pl_pkg::MODE_INS_POS, 7'd0, 16'hFFFF);
  endtask

  task automatic test_directed_edges();
    send_cmd(pl_pkg::MODE_INS_HEAD, 7'd0, 16'h0000);
    send_cmd(pl_pkg::MODE_INS_TAIL, 7'd0, 16'h1234);
    send_cmd(pl_pkg::MODE_INS_POS, 7'(shadow_cnt), 16'hABCD);  // position at count acts as tail
    send_cmd(pl_pkg::MODE_INS_POS, 7'd1, 16'h5555);
    // last by position moves the tail
    send_cmd(pl_pkg::MODE_REM_POS, 7'(shadow_cnt - 1), 16'h0000);
    send_cmd(pl_pkg::MODE_INS_TAIL, 7'd0, 16'h00FF);
    send_cmd(pl_pkg::MODE_REM_TAIL, 7'd0, 16'h0000);
    send_cmd(pl_pkg::MODE_REM_POS, 7'(shadow_cnt), 16'h0000);
    send_cmd(pl_pkg::MODE_REM_POS, 7'd0, 16'h0000);
    send_cmd(pl_pkg::MODE_REM_HEAD, 7'd0, 16'h0000);
    send_cmd(3'd6, 7'd64, 16'hAAAA);
    send_cmd(3'd7, 7'd0, 16'h5555);
  endtask

  task automatic test_full_list();
    gap_pct   = 20;
    stall_pct = 20;
    while (shadow_cnt < LIST_CAP)
      send_cmd(INS_MODES[$urandom_range(2)], 7'($urandom_range(shadow_cnt)), rand_value());
    send_cmd(pl_pkg::MODE_INS_HEAD, 7'd0, 16'hFFFF);
    send_cmd(pl_pkg::MODE_INS_TAIL, 7'd0, 16'hFFFF);
    send_cmd(pl_pkg::MODE_INS_POS, 7'd64, 16'hFFFF);
    send_cmd(pl_pkg::MODE_INS_POS, 7'd127, 16'hFFFF);  // full wins over bad position
    send_cmd(pl_pkg::MODE_REM_POS, 7'd64, 16'h0000);
    send_cmd(pl_pkg::MODE_REM_POS, 7'd63, 16'h0000);
    send_cmd(pl_pkg::MODE_INS_TAIL, 7'd0, 16'hC0DE);
    send_cmd(pl_pkg::MODE_REM_TAIL, 7'd0, 16'h0000);
    while (shadow_cnt != 0)
      send_cmd(REM_MODES[$urandom_range(2)], 7'($urandom_range(shadow_cnt - 1)), rand_value());
  endtask

  task automatic test_random_mix();
    int unsigned fill_goal;
    bit          grow;
    logic [6:0]  pos;
    for (int seg = 0; seg < 12; seg++) begin
      fill_goal = ($urandom_range(9) == 0) ? $urandom_range(64, 40) : $urandom_range(16);
      case (seg % 3)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 25; stall_pct = 25; end
        default: begin gap_pct = 60; stall_pct = 60; end
      endcase
      repeat (100) begin
        grow = (shadow_cnt < fill_goal) ? ($urandom_range(99) < 75) : ($urandom_range(99) < 25);
        if ($urandom_range(9) == 0) pos = 7'($urandom_range(127));
        else if (grow) pos = 7'($urandom_range(shadow_cnt));
        else pos = 7'((shadow_cnt == 0) ? 0 : $urandom_range(shadow_cnt - 1));
        if ($urandom_range(99) < 3)
          send_cmd(3'($urandom_range(7, 6)), pos, rand_value());
        else if (grow)
          send_cmd(INS_MODES[$urandom_range(2)], pos, rand_value());
        else
          send_cmd(REM_MODES[$urandom_range(2)], pos, rand_value());
      end
    end
  endtask

  always @(posedge clk_i) begin : stall_gen
    int unsigned n;
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      n = idle_len(stall_pct);
      out_stall_i <= (n != 0);
      stall_left  <= (n != 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk_i) begin : reply_check
    list_reply_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result beat", count_o, 0);
      end else begin
        exp = pending_replies.pop_front();
        if (removed_value_o !== exp.removed)
          report_mismatch("removed_value", removed_value_o, exp.removed);
        if (status_o !== exp.status) report_mismatch("status", status_o, exp.status);
        if (count_o !== exp.count) report_mismatch("count", count_o, exp.count);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("positional_list_engine regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_directed_edges();
    test_full_list();
    test_random_mix();
    in_valid_i <= 1'b0;
    stall_pct = 20;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0)
      report_mismatch("results still outstanding", pending_replies.size(), 0);
    if (err_cnt == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

endmodule
